/* hw/rtl/pfe_pkg.sv */
// shared types, constants and arithmetic helpers of the particle force step block
`default_nettype none
package pfe_pkg;
  localparam int DATA_W          = 32;
  localparam int MAX_FORCES_DEF  = 8;
  localparam int SLOT_W          = 3;
  localparam int KIND_W          = 2;
  localparam int FCNT_W          = 4;
  localparam int CFG_IDX_W       = 1;

  localparam logic signed [DATA_W-1:0] TS_RESET = 32'sd1092;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_COUNT = 1'b1;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_START, DP_ENT, DP_RDIF, DP_SQM, DP_SQA, DP_SQZ,
    DP_UST, DP_UW, DP_PM, DP_PA, DP_QST, DP_QW, DP_DMUL, DP_DQ,
    DP_TM, DP_TA, DP_VA, DP_POS, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              s_zero;
    logic              sqrt_done;
    logic              div_done;
  } dp_stat_t;

  typedef struct packed {
    logic                     func;
    logic [SLOT_W-1:0]        force_slot;
    logic [KIND_W-1:0]        force_kind;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] strength;
  } pfe_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_pos_z;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic signed [DATA_W-1:0] new_vel_z;
    logic                     degenerate;
  } pfe_result_t;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 31'd0};
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  // q16.16 product rounding, half up, then clamp
  function automatic logic signed [DATA_W-1:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/pfe_if.sv */
// valid/ready channel interfaces for particle items and results
`default_nettype none
interface pfe_in_if;
  import pfe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [SLOT_W-1:0]        force_slot;
  logic [KIND_W-1:0]        force_kind;
  logic signed [DATA_W-1:0] vec_x;
  logic signed [DATA_W-1:0] vec_y;
  logic signed [DATA_W-1:0] vec_z;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  logic signed [DATA_W-1:0] vel_z;
  logic signed [DATA_W-1:0] strength;
  modport source (output valid, func, force_slot, force_kind, vec_x, vec_y, vec_z,
                  vel_x, vel_y, vel_z, strength, input ready);
  modport sink (input valid, func, force_slot, force_kind, vec_x, vec_y, vec_z,
                vel_x, vel_y, vel_z, strength, output ready);
endinterface

interface pfe_out_if;
  import pfe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_pos_x;
  logic signed [DATA_W-1:0] new_pos_y;
  logic signed [DATA_W-1:0] new_pos_z;
  logic signed [DATA_W-1:0] new_vel_x;
  logic signed [DATA_W-1:0] new_vel_y;
  logic signed [DATA_W-1:0] new_vel_z;
  logic                     degenerate;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, degenerate, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, degenerate, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pfe_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/pfe_isqrt.sv */
// iterative 64-bit integer square root, two radicand bits per cycle
`default_nettype none
module pfe_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             busy,
  output logic [31:0]      root
);
  logic [63:0] xr;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy) begin
      busy <= |bitv[63:2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      res  <= 64'd0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (xr >= trial) begin
        xr  <= xr - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/pfe_div.sv */
// iterative 64-bit unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module pfe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             busy,
  output logic [63:0]      quot
);
  logic [63:0] rem;
  logic [63:0] dsr;
  logic [5:0]  cnt;
  logic [64:0] t;

  assign t = {rem, quot[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= 64'd0;
      quot <= dividend;
      dsr  <= divisor;
      cnt  <= 6'd63;
    end else if (busy) begin
      if (t >= {1'b0, dsr}) begin
        rem  <= 64'(t - {1'b0, dsr});
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= t[63:0];
        quot <= {quot[62:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/pfe_dp.sv */
// datapath: force table, particle registers, shared multiplier, root and divide units
`default_nettype none
module pfe_dp #(
  parameter int MAX_FORCES = pfe_pkg::MAX_FORCES_DEF,
  localparam int AW = (MAX_FORCES > 1) ? $clog2(MAX_FORCES) : 1,
  localparam int CW = $clog2(MAX_FORCES + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire pfe_pkg::dp_cmd_t                 cmd,
  input  wire logic [CW-1:0]                    j,
  input  wire logic signed [pfe_pkg::DATA_W-1:0] ts,
  input  wire pfe_pkg::pfe_item_t               item,
  output pfe_pkg::dp_stat_t                     st,
  output pfe_pkg::pfe_result_t                  res
);
  import pfe_pkg::*;

  localparam int RAM_W = KIND_W + 4 * DATA_W;

  logic signed [DATA_W-1:0] pos [3];
  logic signed [DATA_W-1:0] vel [3];
  logic signed [DATA_W-1:0] fv [3];
  logic signed [DATA_W-1:0] r [3];
  logic signed [DATA_W-1:0] mag;
  logic signed [DATA_W-1:0] u;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] dv;
  logic signed [63:0]       prod;
  logic signed [63:0]       p;
  logic [63:0]              s;
  logic                     degen;
  logic [MAX_FORCES-1:0]    valid;

  logic [1:0]               i;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic                     slot_ok;
  logic                     we;
  logic [RAM_W-1:0]         wdata;
  logic [RAM_W-1:0]         rdata;
  logic signed [DATA_W-1:0] ma;
  logic signed [DATA_W-1:0] mb;
  logic [31:0]              rabs;
  logic [63:0]              pabs;
  logic                     sq_start;
  logic                     sq_busy;
  logic [31:0]              n;
  logic                     dv_start;
  logic                     dv_busy;
  logic [63:0]              dv_num;
  logic [63:0]              dv_den;
  logic [63:0]              q;

  assign i       = cmd.idx;
  assign raddr   = j[AW-1:0];
  assign waddr   = AW'(item.force_slot);
  assign slot_ok = 32'(item.force_slot) < 32'(MAX_FORCES);
  assign we      = (cmd.op == DP_LOAD) && slot_ok;
  assign wdata   = {item.force_kind, item.strength, item.vec_z, item.vec_y, item.vec_x};

  pfe_ram #(.WIDTH(RAM_W), .DEPTH(MAX_FORCES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  assign st.kind      = valid[raddr] ? rdata[RAM_W-1 -: KIND_W] : KIND_NONE;
  assign st.s_zero    = (s == 64'd0);
  assign st.sqrt_done = !sq_busy;
  assign st.div_done  = !dv_busy;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      DP_PM: begin
        ma = mag;
        mb = u;
      end
      DP_DMUL: begin
        ma = mag;
        mb = fv[i];
      end
      DP_TM: begin
        ma = ts;
        mb = acc;
      end
      default: begin
        ma = r[i];
        mb = r[i];
      end
    endcase
  end

  assign rabs = r[i][DATA_W-1] ? (32'd0 - r[i]) : r[i];
  assign pabs = p[63] ? (64'd0 - p) : p;

  assign sq_start = (cmd.op == DP_SQZ) && !st.s_zero;
  assign dv_start = (cmd.op == DP_UST) || (cmd.op == DP_QST);
  assign dv_num   = (cmd.op == DP_UST) ? {16'd0, rabs, 16'd0} : {pabs[47:0], 16'd0};
  assign dv_den   = (cmd.op == DP_UST) ? {32'd0, n} : s;

  pfe_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (s),
    .busy  (sq_busy),
    .root  (n)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (dv_den),
    .busy     (dv_busy),
    .quot     (q)
  );

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
    case (cmd.op)
      DP_START: begin
        pos[0] <= item.vec_x;
        pos[1] <= item.vec_y;
        pos[2] <= item.vec_z;
        vel[0] <= item.vel_x;
        vel[1] <= item.vel_y;
        vel[2] <= item.vel_z;
        degen  <= 1'b0;
      end
      DP_ENT: begin
        fv[0] <= rdata[DATA_W-1:0];
        fv[1] <= rdata[2*DATA_W-1:DATA_W];
        fv[2] <= rdata[3*DATA_W-1:2*DATA_W];
        mag   <= rdata[4*DATA_W-1:3*DATA_W];
      end
      DP_RDIF: begin
        for (int k = 0; k < 3; k++) begin
          r[k] <= sat32(64'(fv[k]) - 64'(pos[k]));
        end
        s <= 64'd0;
      end
      DP_SQA: begin
        s <= s + prod;
      end
      DP_SQZ: begin
        if (st.s_zero) begin
          degen <= 1'b1;
        end
      end
      DP_UW: begin
        u <= r[i][DATA_W-1] ? (32'd0 - q[31:0]) : q[31:0];
      end
      DP_PA: begin
        p <= prod;
      end
      DP_QW: begin
        if (p[63]) begin
          acc <= (q > 64'h80000000) ? {1'b1, 31'd0} : 32'(64'd0 - q);
        end else begin
          acc <= (q > 64'h7fffffff) ? 32'sh7fffffff : q[31:0];
        end
      end
      DP_DQ: begin
        acc <= qround(prod);
      end
      DP_TA: begin
        dv <= qround(prod);
      end
      DP_VA: begin
        vel[i] <= sat32(64'(vel[i]) + 64'(dv));
      end
      DP_POS: begin
        for (int k = 0; k < 3; k++) begin
          pos[k] <= sat32(64'(pos[k]) + 64'(vel[k]));
        end
      end
      DP_OUT: begin
        res.new_pos_x  <= pos[0];
        res.new_pos_y  <= pos[1];
        res.new_pos_z  <= pos[2];
        res.new_vel_x  <= vel[0];
        res.new_vel_y  <= vel[1];
        res.new_vel_z  <= vel[2];
        res.degenerate <= degen;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/pfe_ctrl.sv */
// sequencer that walks the force table and drives the datapath
`default_nettype none
module pfe_ctrl #(
  parameter int MAX_FORCES = pfe_pkg::MAX_FORCES_DEF,
  localparam int CW = $clog2(MAX_FORCES + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_func,
  output logic                            in_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  input  wire logic [pfe_pkg::FCNT_W-1:0] force_count,
  input  wire pfe_pkg::dp_stat_t          st,
  output pfe_pkg::dp_cmd_t                cmd,
  output logic [CW-1:0]                   j
);
  import pfe_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_CHK  = 21'h000002,
    S_ENT  = 21'h000004,
    S_RDIF = 21'h000008,
    S_SQM  = 21'h000010,
    S_SQA  = 21'h000020,
    S_SQZ  = 21'h000040,
    S_SQRT = 21'h000080,
    S_UST  = 21'h000100,
    S_UW   = 21'h000200,
    S_PM   = 21'h000400,
    S_PA   = 21'h000800,
    S_QST  = 21'h001000,
    S_QW   = 21'h002000,
    S_DMUL = 21'h004000,
    S_DQ   = 21'h008000,
    S_TM   = 21'h010000,
    S_TA   = 21'h020000,
    S_VA   = 21'h040000,
    S_POS  = 21'h080000,
    S_OUT  = 21'h100000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] j_next;
  logic [1:0]    idx;
  logic [1:0]    idx_next;
  logic          is_pt;
  logic          is_pt_next;
  logic          out_valid_next;
  logic [CW-1:0] cnt_lim;
  logic          load_out;

  assign cnt_lim  = (32'(force_count) > 32'(MAX_FORCES)) ? CW'(MAX_FORCES) : CW'(force_count);
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    j_next         = j;
    idx_next       = idx;
    is_pt_next     = is_pt;
    cmd.op         = DP_NOP;
    cmd.idx        = idx;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            cmd.op     = DP_START;
            j_next     = '0;
            state_next = S_CHK;
          end else begin
            cmd.op = DP_LOAD;
          end
        end
      end
      S_CHK: begin
        state_next = (j == cnt_lim) ? S_POS : S_ENT;
      end
      S_ENT: begin
        cmd.op   = DP_ENT;
        idx_next = 2'd0;
        case (st.kind)
          KIND_POINT: begin
            is_pt_next = 1'b1;
            state_next = S_RDIF;
          end
          KIND_DIR: begin
            is_pt_next = 1'b0;
            state_next = S_DMUL;
          end
          default: begin
            j_next     = j + CW'(1);
            state_next = S_CHK;
          end
        endcase
      end
      S_RDIF: begin
        cmd.op     = DP_RDIF;
        state_next = S_SQM;
      end
      S_SQM: begin
        cmd.op     = DP_SQM;
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.op = DP_SQA;
        if (idx == 2'd2) begin
          idx_next   = 2'd0;
          state_next = S_SQZ;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_SQM;
        end
      end
      S_SQZ: begin
        cmd.op = DP_SQZ;
        if (st.s_zero) begin
          j_next     = j + CW'(1);
          state_next = S_CHK;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (st.sqrt_done) begin
          state_next = S_UST;
        end
      end
      S_UST: begin
        cmd.op     = DP_UST;
        state_next = S_UW;
      end
      S_UW: begin
        cmd.op = DP_UW;
        if (st.div_done) begin
          state_next = S_PM;
        end
      end
      S_PM: begin
        cmd.op     = DP_PM;
        state_next = S_PA;
      end
      S_PA: begin
        cmd.op     = DP_PA;
        state_next = S_QST;
      end
      S_QST: begin
        cmd.op     = DP_QST;
        state_next = S_QW;
      end
      S_QW: begin
        cmd.op = DP_QW;
        if (st.div_done) begin
          state_next = S_TM;
        end
      end
      S_DMUL: begin
        cmd.op     = DP_DMUL;
        state_next = S_DQ;
      end
      S_DQ: begin
        cmd.op     = DP_DQ;
        state_next = S_TM;
      end
      S_TM: begin
        cmd.op     = DP_TM;
        state_next = S_TA;
      end
      S_TA: begin
        cmd.op     = DP_TA;
        state_next = S_VA;
      end
      S_VA: begin
        cmd.op = DP_VA;
        if (idx == 2'd2) begin
          idx_next   = 2'd0;
          j_next     = j + CW'(1);
          state_next = S_CHK;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = is_pt ? S_UST : S_DMUL;
        end
      end
      S_POS: begin
        cmd.op     = DP_POS;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          cmd.op         = DP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      idx       <= 2'd0;
      is_pt     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      j         <= j_next;
      idx       <= idx_next;
      is_pt     <= is_pt_next;
      out_valid <= out_valid_next;
    end
  end

  a_j_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (j <= cnt_lim))
    else $error("force index ran past the applied count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd3))
    else $error("component index out of range");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && state == S_IDLE))
    else $error("finished particle did not reach the output register");
endmodule
`default_nettype wire

/* hw/rtl/particle_force_euler_step_top.sv */
// top level of the explicit euler particle force step block
// One item is taken at a time on the input channel. A load item (func 0) writes one force
// table entry. A step item (func 1) walks the first force_count entries (clamped to
// MAX_FORCES) and then updates the position. The costliest entry is a point force at
// nonzero distance, which uses the shared one-bit-per-cycle 64-bit divider six times
// (two divisions per component) plus the square root.
// The result sits in an output register until transferred; the next item is accepted
// meanwhile but its result waits for that register. No clearing pass is needed after
// reset: unwritten entries read as "no force" through per-entry valid flags.
`default_nettype none
module particle_force_euler_step_top #(
  parameter int MAX_FORCES = pfe_pkg::MAX_FORCES_DEF,
  localparam int CW = $clog2(MAX_FORCES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pfe_in_if.sink                             in,
  pfe_out_if.source                          out,
  input  wire logic                          cfg_we,
  input  wire logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pfe_pkg::DATA_W-1:0]    cfg_data
);
  import pfe_pkg::*;

  // configuration registers
  logic signed [DATA_W-1:0] time_step;
  logic [FCNT_W-1:0]        force_count;

  // controller/datapath link
  dp_cmd_t     cmd;
  dp_stat_t    st;
  logic [CW-1:0] j;
  pfe_item_t   item;
  pfe_result_t res;
  logic        out_valid;
  logic        in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TS_RESET;
      force_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIME_STEP: begin
          time_step <= cfg_data;
        end
        CFG_FORCE_COUNT: begin
          force_count <= cfg_data[FCNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input payload gathered for the datapath
  assign item.func       = in.func;
  assign item.force_slot = in.force_slot;
  assign item.force_kind = in.force_kind;
  assign item.vec_x      = in.vec_x;
  assign item.vec_y      = in.vec_y;
  assign item.vec_z      = in.vec_z;
  assign item.vel_x      = in.vel_x;
  assign item.vel_y      = in.vel_y;
  assign item.vel_z      = in.vel_z;
  assign item.strength   = in.strength;
  assign in.ready        = in_ready;

  pfe_ctrl #(.MAX_FORCES(MAX_FORCES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in.valid),
    .in_func     (in.func),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out.ready),
    .force_count (force_count),
    .st          (st),
    .cmd         (cmd),
    .j           (j)
  );

  pfe_dp #(.MAX_FORCES(MAX_FORCES)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .j    (j),
    .ts   (time_step),
    .item (item),
    .st   (st),
    .res  (res)
  );

  // output register contents to the result channel
  assign out.valid      = out_valid;
  assign out.new_pos_x  = res.new_pos_x;
  assign out.new_pos_y  = res.new_pos_y;
  assign out.new_pos_z  = res.new_pos_z;
  assign out.new_vel_x  = res.new_vel_x;
  assign out.new_vel_y  = res.new_vel_y;
  assign out.new_vel_z  = res.new_vel_z;
  assign out.degenerate = res.degenerate;
endmodule
`default_nettype wire

/* verif/particle_force_euler_step_top_tb.sv */
// self-checking testbench for the particle force euler step block
`default_nettype none
module particle_force_euler_step_top_tb;
  import pfe_pkg::*;

  // item codes on the func field
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  // cycles with no transfer on either channel before the run is given up
  localparam int STALL_LIMIT = 20000;
  // quiet cycles after the last result, enough for a trailing load
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 930;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  pfe_in_if  in_ch();
  pfe_out_if out_ch();

  particle_force_euler_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the force table and registers, updated as transfers happen
  // ---------------------------------------------------------------------------
  logic [KIND_W-1:0] kind_tbl [MAX_FORCES_DEF];
  longint            vec_tbl  [MAX_FORCES_DEF][3];
  longint            mag_tbl  [MAX_FORCES_DEF];
  longint            step_q;   // time step, q16.16
  int                fcnt;     // force count as written, 4 bits

  pfe_result_t motion_q [$];   // expected particle updates, oldest first

  int errors;
  int steps_sent;
  int loads_sent;
  int results_seen;
  int degen_seen;
  int idle_in;
  int idle_out;
  int quiet_cycles;

  function automatic longint clamp32(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // q16.16 product, round half up, arithmetic shift floors
  function automatic longint fx_mul(longint a, longint b);
    longint t;
    t = (a * b + 64'sd32768) >>> 16;
    return clamp32(t);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one euler step of a particle against the shadow force table
  function automatic pfe_result_t advance_particle(pfe_item_t it);
    longint pos [3];
    longint vel [3];
    longint acc [3];
    longint r [3];
    longint unsigned dist2;
    longint nrm;
    longint u;
    longint p;
    longint unsigned mp;
    longint unsigned q;
    int cnt;
    bit degen;
    bit active;
    pfe_result_t res;
    pos[0] = longint'($signed(it.vec_x));
    pos[1] = longint'($signed(it.vec_y));
    pos[2] = longint'($signed(it.vec_z));
    vel[0] = longint'($signed(it.vel_x));
    vel[1] = longint'($signed(it.vel_y));
    vel[2] = longint'($signed(it.vel_z));
    degen = 1'b0;
    cnt = (fcnt > MAX_FORCES_DEF) ? MAX_FORCES_DEF : fcnt;
    for (int j = 0; j < cnt; j++) begin
      active = 1'b0;
      if (kind_tbl[j] == KIND_POINT) begin
        dist2 = 0;
        for (int i = 0; i < 3; i++) begin
          r[i] = clamp32(vec_tbl[j][i] - pos[i]);
          dist2 = dist2 + longint'(r[i] * r[i]);
        end
        if (dist2 == 0) begin
          // particle on the force position: skipped, flagged
          degen = 1'b1;
        end else begin
          active = 1'b1;
          nrm = longint'(int_sqrt(dist2));
          for (int i = 0; i < 3; i++) begin
            u = (r[i] * 64'sd65536) / nrm;
            p = mag_tbl[j] * u;
            mp = (p < 0) ? longint'(-p) : longint'(p);
            q = (mp << 16) / dist2;
            if (p < 0) acc[i] = (q > 64'h80000000) ? Q_MIN : -longint'(q);
            else acc[i] = (q > 64'h7fffffff) ? Q_MAX : longint'(q);
          end
        end
      end else if (kind_tbl[j] == KIND_DIR) begin
        active = 1'b1;
        for (int i = 0; i < 3; i++) acc[i] = fx_mul(mag_tbl[j], vec_tbl[j][i]);
      end
      if (active) begin
        for (int i = 0; i < 3; i++) vel[i] = clamp32(vel[i] + fx_mul(step_q, acc[i]));
      end
    end
    for (int i = 0; i < 3; i++) pos[i] = clamp32(pos[i] + vel[i]);
    res.new_pos_x = pos[0][31:0];
    res.new_pos_y = pos[1][31:0];
    res.new_pos_z = pos[2][31:0];
    res.new_vel_x = vel[0][31:0];
    res.new_vel_y = vel[1][31:0];
    res.new_vel_z = vel[2][31:0];
    res.degenerate = degen;
    return res;
  endfunction

  function automatic void store_force(pfe_item_t it);
    kind_tbl[it.force_slot] = it.force_kind;
    vec_tbl[it.force_slot][0] = longint'($signed(it.vec_x));
    vec_tbl[it.force_slot][1] = longint'($signed(it.vec_y));
    vec_tbl[it.force_slot][2] = longint'($signed(it.vec_z));
    mag_tbl[it.force_slot] = longint'($signed(it.strength));
  endfunction

  // ---------------------------------------------------------------------------
  // item builders and random values
  // ---------------------------------------------------------------------------
  function automatic pfe_item_t force_item(int slot, logic [KIND_W-1:0] kind,
      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
      logic signed [31:0] mag);
    pfe_item_t it;
    it.func = FUNC_LOAD;
    it.force_slot = slot[SLOT_W-1:0];
    it.force_kind = kind;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    // velocity is unused on a load, keep it noisy
    it.vel_x = $urandom;
    it.vel_y = $urandom;
    it.vel_z = $urandom;
    it.strength = mag;
    return it;
  endfunction

  function automatic pfe_item_t particle_item(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] vx,
      logic signed [31:0] vy, logic signed [31:0] vz);
    pfe_item_t it;
    it.func = FUNC_STEP;
    // slot, kind and strength are unused on a step
    it.force_slot = SLOT_W'($urandom);
    it.force_kind = KIND_W'($urandom);
    it.vec_x = px;
    it.vec_y = py;
    it.vec_z = pz;
    it.vel_x = vx;
    it.vel_y = vy;
    it.vel_z = vz;
    it.strength = $urandom;
    return it;
  endfunction

  function automatic pfe_result_t motion(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz, logic signed [31:0] vx, logic signed [31:0] vy,
      logic signed [31:0] vz, logic degen);
    pfe_result_t res;
    res.new_pos_x = px;
    res.new_pos_y = py;
    res.new_pos_z = pz;
    res.new_vel_x = vx;
    res.new_vel_y = vy;
    res.new_vel_z = vz;
    res.degenerate = degen;
    return res;
  endfunction

  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return 32'sd0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  task automatic send_item(pfe_item_t it, bit typed, pfe_result_t typed_res);
    @(negedge clk);
    while ($urandom_range(99) < idle_in) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= it.func;
    in_ch.force_slot <= it.force_slot;
    in_ch.force_kind <= it.force_kind;
    in_ch.vec_x      <= it.vec_x;
    in_ch.vec_y      <= it.vec_y;
    in_ch.vec_z      <= it.vec_z;
    in_ch.vel_x      <= it.vel_x;
    in_ch.vel_y      <= it.vel_y;
    in_ch.vel_z      <= it.vel_z;
    in_ch.strength   <= it.strength;
    do @(posedge clk); while (!in_ch.ready);
    // transfer taken at this edge: predict now
    if (it.func == FUNC_LOAD) begin
      store_force(it);
      loads_sent++;
    end else begin
      motion_q.insert(motion_q.size(), typed ? typed_res : advance_particle(it));
      steps_sent++;
    end
  endtask

  // registers only change with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_TIME_STEP) step_q = longint'($signed(value));
    else fcnt = int'(value[FCNT_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= idle_out);
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pfe_result_t want;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (motion_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, pos %h %h %h", $time,
                   out_ch.new_pos_x, out_ch.new_pos_y, out_ch.new_pos_z);
        end else begin
          want = motion_q.pop_front();
          if (want.degenerate) degen_seen++;
          check_field("new_pos_x", want.new_pos_x, out_ch.new_pos_x);
          check_field("new_pos_y", want.new_pos_y, out_ch.new_pos_y);
          check_field("new_pos_z", want.new_pos_z, out_ch.new_pos_z);
          check_field("new_vel_x", want.new_vel_x, out_ch.new_vel_x);
          check_field("new_vel_y", want.new_vel_y, out_ch.new_vel_y);
          check_field("new_vel_z", want.new_vel_z, out_ch.new_vel_z);
          check_field("degenerate", {31'd0, want.degenerate}, {31'd0, out_ch.degenerate});
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, motion_q.size());
        $display("particle_force_euler_step_top_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table: register writes and items, typed results where obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          value;
    pfe_item_t            it;
    bit                   typed;
    pfe_result_t          res;
  } row_t;

  row_t plan [$];

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    row_t r;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.value = value;
    r.typed = 1'b0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void plan_item(pfe_item_t it, bit typed, pfe_result_t res);
    row_t r;
    r.is_reg = 1'b0;
    r.it = it;
    r.typed = typed;
    r.res = res;
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    pfe_result_t none_res;
    logic signed [31:0] pv [3];
    logic signed [31:0] vv [3];
    longint t;
    int slot;
    int target;
    int r;

    errors = 0;
    steps_sent = 0;
    loads_sent = 0;
    results_seen = 0;
    degen_seen = 0;
    quiet_cycles = 0;
    idle_in = 25;
    idle_out = 62;
    step_q = 64'sd1092;
    fcnt = 0;
    for (int j = 0; j < MAX_FORCES_DEF; j++) begin
      kind_tbl[j] = KIND_NONE;
      mag_tbl[j] = 0;
      for (int i = 0; i < 3; i++) vec_tbl[j][i] = 0;
    end
    none_res = '0;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.force_slot = '0;
    in_ch.force_kind = KIND_NONE;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    in_ch.strength = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset no force applies: position just adds velocity, saturating
    plan_item(particle_item(S_MAX, S_MAX, 32'sd0, S_MAX, 32'sd1, 32'sd0), 1'b1,
              motion(S_MAX, S_MAX, 32'sd0, S_MAX, 32'sd1, 32'sd0, 1'b0));
    plan_item(particle_item(S_MIN, S_MIN, 32'sd5, S_MIN, -32'sd1, -32'sd1), 1'b1,
              motion(S_MIN, S_MIN, 32'sd4, S_MIN, -32'sd1, -32'sd1, 1'b0));
    plan_item(particle_item(32'sd0, S_MAX, S_MIN, -32'sd1, S_MIN, S_MAX), 1'b1,
              motion(-32'sd1, -32'sd1, -32'sd1, -32'sd1, S_MIN, S_MAX, 1'b0));
    // fill the table: every kind, extremes of vectors and strengths
    plan_item(force_item(0, KIND_POINT, 32'sh000a_0000, 32'sh0014_0000, 32'sh001e_0000,
                         32'sh0001_0000), 1'b0, none_res);
    plan_item(force_item(1, KIND_DIR, 32'sh0001_0000, 32'sd0, -32'sh0001_0000, S_MAX),
              1'b0, none_res);
    plan_item(force_item(2, 2'd3, S_MAX, S_MIN, 32'sd7, S_MAX), 1'b0, none_res);
    plan_item(force_item(3, KIND_NONE, S_MIN, S_MIN, S_MIN, S_MIN), 1'b0, none_res);
    plan_item(force_item(4, KIND_POINT, S_MAX, S_MIN, 32'sd0, S_MIN), 1'b0, none_res);
    plan_item(force_item(5, KIND_DIR, S_MIN, S_MAX, 32'sd1, S_MIN), 1'b0, none_res);
    plan_item(force_item(6, KIND_POINT, 32'sd0, 32'sd0, 32'sd0, 32'sd1), 1'b0, none_res);
    plan_item(force_item(7, KIND_DIR, 32'sd3, -32'sd3, 32'sh0000_8000, 32'sh0002_0000),
              1'b0, none_res);
    // particle right on the only applied point force: skipped and flagged
    plan_reg(CFG_FORCE_COUNT, 32'd1);
    plan_item(particle_item(32'sh000a_0000, 32'sh0014_0000, 32'sh001e_0000, 32'sd1,
                            32'sd2, 32'sd3), 1'b1,
              motion(32'sh000a_0001, 32'sh0014_0002, 32'sh001e_0003, 32'sd1, 32'sd2,
                     32'sd3, 1'b1));
    plan_item(particle_item(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0), 1'b0,
              none_res);
    // whole table at the largest time steps
    plan_reg(CFG_TIME_STEP, 32'h7fff_ffff);
    plan_reg(CFG_FORCE_COUNT, 32'd8);
    plan_item(particle_item(32'sd5, -32'sd5, 32'sh0100_0000, 32'sd0, 32'sd0, 32'sd0),
              1'b0, none_res);
    plan_item(particle_item(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 32'sd0), 1'b0, none_res);
    // count above the table size walks all eight entries
    plan_reg(CFG_TIME_STEP, 32'h8000_0000);
    plan_reg(CFG_FORCE_COUNT, 32'hffff_ffff);
    plan_item(particle_item(32'sh0003_0000, 32'sh0003_0000, -32'sh0003_0000, 32'sd9,
                            32'sd9, 32'sd9), 1'b0, none_res);
    // zero time step: velocity stays, the point force at the origin is flagged
    plan_reg(CFG_TIME_STEP, 32'd0);
    plan_reg(CFG_FORCE_COUNT, 32'd8);
    plan_item(particle_item(32'sd0, 32'sd0, 32'sd0, 32'sd11, -32'sd12, S_MAX), 1'b1,
              motion(32'sd11, -32'sd12, S_MAX, 32'sd11, -32'sd12, S_MAX, 1'b1));

    foreach (plan[k]) begin
      if (plan[k].is_reg) write_reg(plan[k].idx, plan[k].value);
      else send_item(plan[k].it, plan[k].typed, plan[k].res);
    end

    // random part: phases of registers, table loads and particle bursts
    target = steps_sent + loads_sent + RANDOM_ITEMS;
    while (steps_sent + loads_sent < target) begin
      // idling pattern follows progress through the random part
      if (target - (steps_sent + loads_sent) > 2 * RANDOM_ITEMS / 3) begin
        idle_in = 25;
        idle_out = 62;
      end else if (target - (steps_sent + loads_sent) > RANDOM_ITEMS / 3) begin
        idle_in = 62;
        idle_out = 25;
      end else begin
        idle_in = 0;
        idle_out = 0;
      end

      case ($urandom_range(5))
        0: write_reg(CFG_TIME_STEP, 32'd1092);
        1: write_reg(CFG_TIME_STEP, $urandom);
        2: write_reg(CFG_TIME_STEP, ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000));
        default: write_reg(CFG_TIME_STEP,
                           32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000));
      endcase
      r = $urandom_range(19);
      if (r < 14) write_reg(CFG_FORCE_COUNT, r % 6);
      else if (r < 17) write_reg(CFG_FORCE_COUNT, 8);
      else write_reg(CFG_FORCE_COUNT,
                     {28'($urandom_range(32'hffff)), 4'($urandom_range(15, 9))});

      repeat ($urandom_range(4, 1)) begin
        send_item(force_item($urandom_range(7), KIND_W'($urandom_range(3)), rand_fixed(),
                             rand_fixed(), rand_fixed(), rand_fixed()), 1'b0, none_res);
      end

      repeat ($urandom_range(30, 10)) begin
        slot = $urandom_range(7);
        r = $urandom_range(9);
        for (int i = 0; i < 3; i++) begin
          if (r < 7) begin
            // near a table entry so point forces give usable magnitudes
            t = vec_tbl[slot][i] + longint'($signed($urandom_range(32'h0008_0000)))
                - 64'sd262144;
            t = clamp32(t);
            pv[i] = t[31:0];
          end else if (r == 7) begin
            pv[i] = vec_tbl[slot][i][31:0];
          end else begin
            pv[i] = rand_fixed();
          end
          vv[i] = rand_fixed();
        end
        send_item(particle_item(pv[0], pv[1], pv[2], vv[0], vv[1], vv[2]), 1'b0,
                  none_res);
      end
    end

    // drain: every expected result back, then a few quiet cycles
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d particle steps and %0d table loads sent, %0d results checked",
             steps_sent, loads_sent, results_seen);
    $display("%0d results flagged a zero-distance point force, %0d mismatches",
             degen_seen, errors);
    if (errors == 0) begin
      $display("particle_force_euler_step_top_tb OK");
    end else begin
      $display("particle_force_euler_step_top_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
